FILE: src/line_draw_framebuffer_unit_assert.svh
// Assertion macros for the line draw frame buffer unit.
`ifndef LINE_DRAW_FRAMEBUFFER_UNIT_ASSERT_SVH
`define LINE_DRAW_FRAMEBUFFER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LDFB_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define LDFB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LDFB_ASSERT(label, clk, rstn, prop)
`define LDFB_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: src/ldfb_pkg.sv
package ldfb_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 320;
    localparam int DISPLAY_HEIGHT_DEF = 240;

    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int BADDR_W = 14;
    localparam int ERR_W   = 13;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_TAKE  = 2'd3;

    localparam logic [1:0] PM_CLEAR  = 2'd0;
    localparam logic [1:0] PM_SET    = 2'd1;
    localparam logic [1:0] PM_TOGGLE = 2'd2;
    localparam logic [1:0] PM_KEEP   = 2'd3;

    typedef struct packed {
        logic load;
        logic advance;
    } step_ctrl_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } step_stat_t;

endpackage

FILE: src/line_draw_framebuffer_unit.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  opcode, line ends, pixel mode, byte address
// m_        out        m_valid / m_ready  read data, dirty low/high, dirty flag
//
// One command at a time; s_ready is high only while idle.
// After reset a clearing pass writes every store byte.
// Draw: each on-display pixel is read and written back; off-display ones are skipped.
// Clear sweeps every byte; read passes S_RD_ISSUE, S_RD_CAPT; take goes to S_FINISH.
// All pixel and clear traffic goes through the single store port.
// A finished result waits in the output register; the next command is still accepted.
`include "line_draw_framebuffer_unit_assert.svh"

module line_draw_framebuffer_unit
    import ldfb_pkg::*;
    #(
    parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
    )
    (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [X_W-1:0]     s_x_start,
    input  logic [Y_W-1:0]     s_y_start,
    input  logic [X_W-1:0]     s_x_end,
    input  logic [Y_W-1:0]     s_y_end,
    input  logic [1:0]         s_pixel_mode,
    input  logic [BADDR_W-1:0] s_byte_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_read_data,
    output logic [BADDR_W-1:0] m_dirty_low,
    output logic [BADDR_W-1:0] m_dirty_high,
    output logic               m_dirty_flag
    );

    localparam int ROW_BYTES  = (DISPLAY_WIDTH + 7) / 8;
    localparam int STORE_SIZE = ROW_BYTES * DISPLAY_HEIGHT;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_PLOT_RD,
        S_PLOT_WR,
        S_RD_ISSUE,
        S_RD_CAPT,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   sweep_cnt_reg;
    logic                reply_reg;
    logic [1:0]          op_reg, mode_reg;
    logic [BADDR_W-1:0]  baddr_reg;
    logic [7:0]          data_reg;
    logic [ADDR_W-1:0]   low_mark_reg, high_mark_reg;
    logic                pending_reg;
    logic                m_valid_reg;
    logic [7:0]          m_read_data_reg;
    logic [BADDR_W-1:0]  m_dirty_low_reg, m_dirty_high_reg;
    logic                m_dirty_flag_reg;

    step_ctrl_t          step_ctrl;
    step_stat_t          step_stat;
    logic                accept, on_disp, baddr_ok;
    logic [31:0]         pix_idx;
    logic [ADDR_W-1:0]   pix_addr, ram_addr;
    logic [7:0]          bit_mask, new_byte, ram_wdata, ram_rdata;
    logic                ram_we;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign step_ctrl.load    = accept && (s_opcode == OP_DRAW);
    assign step_ctrl.advance = !step_stat.last &&
        ((state_reg == S_PLOT_WR) || ((state_reg == S_PLOT_RD) && !on_disp));

    ldfb_stepper u_stepper (
        .clk     (aclk),
        .ctrl    (step_ctrl),
        .x_start (s_x_start),
        .y_start (s_y_start),
        .x_end   (s_x_end),
        .y_end   (s_y_end),
        .stat    (step_stat)
    );

    assign on_disp  = (32'(step_stat.x) < 32'(DISPLAY_WIDTH)) &&
                      (32'(step_stat.y) < 32'(DISPLAY_HEIGHT));
    assign pix_idx  = 32'(step_stat.y) * 32'(ROW_BYTES) + 32'(step_stat.x[X_W-1:3]);
    assign pix_addr = pix_idx[ADDR_W-1:0];
    assign bit_mask = 8'h80 >> step_stat.x[2:0];
    assign baddr_ok = 32'(baddr_reg) < 32'(STORE_SIZE);

    always_comb begin
        unique case (mode_reg)
            PM_CLEAR:  new_byte = ram_rdata & ~bit_mask;
            PM_SET:    new_byte = ram_rdata | bit_mask;
            PM_TOGGLE: new_byte = ram_rdata ^ bit_mask;
            PM_KEEP:   new_byte = ram_rdata;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = pix_addr;
        ram_wdata = '0;
        unique case (state_reg)
            S_SWEEP: begin
                ram_we   = 1'b1;
                ram_addr = sweep_cnt_reg;
            end
            S_PLOT_WR: begin
                ram_we    = 1'b1;
                ram_wdata = new_byte;
            end
            S_RD_ISSUE: begin
                ram_addr = ADDR_W'(baddr_reg);
            end
            default: begin
            end
        endcase
    end

    ldfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            sweep_cnt_reg <= '0;
            reply_reg     <= 1'b0;
            low_mark_reg  <= LAST_ADDR;
            high_mark_reg <= '0;
            pending_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_opcode;
                        mode_reg  <= s_pixel_mode;
                        baddr_reg <= s_byte_address;
                        unique case (s_opcode)
                            OP_DRAW: begin
                                pending_reg <= 1'b1;
                                state_reg   <= S_PLOT_RD;
                            end
                            OP_CLEAR: begin
                                low_mark_reg  <= '0;
                                high_mark_reg <= LAST_ADDR;
                                pending_reg   <= 1'b1;
                                sweep_cnt_reg <= '0;
                                reply_reg     <= 1'b1;
                                state_reg     <= S_SWEEP;
                            end
                            OP_READ: state_reg <= S_RD_ISSUE;
                            OP_TAKE: state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_SWEEP: begin
                    sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
                    if (sweep_cnt_reg == LAST_ADDR) begin
                        reply_reg <= 1'b0;
                        state_reg <= reply_reg ? S_FINISH : S_IDLE;
                    end
                end
                S_PLOT_RD: begin
                    if (on_disp) begin
                        state_reg <= S_PLOT_WR;
                    end else if (step_stat.last) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_PLOT_WR: begin
                    if (pix_addr < low_mark_reg) begin
                        low_mark_reg <= pix_addr;
                    end
                    if (pix_addr > high_mark_reg) begin
                        high_mark_reg <= pix_addr;
                    end
                    state_reg <= step_stat.last ? S_FINISH : S_PLOT_RD;
                end
                S_RD_ISSUE: begin
                    state_reg <= S_RD_CAPT;
                end
                S_RD_CAPT: begin
                    data_reg  <= baddr_ok ? ram_rdata : 8'h00;
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_read_data_reg  <= (op_reg == OP_READ) ? data_reg : 8'h00;
                        m_dirty_low_reg  <= BADDR_W'(low_mark_reg);
                        m_dirty_high_reg <= BADDR_W'(high_mark_reg);
                        m_dirty_flag_reg <= pending_reg;
                        if (op_reg == OP_TAKE) begin
                            low_mark_reg  <= LAST_ADDR;
                            high_mark_reg <= '0;
                            pending_reg   <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_dirty_low  = m_dirty_low_reg;
    assign m_dirty_high = m_dirty_high_reg;
    assign m_dirty_flag = m_dirty_flag_reg;

    `LDFB_ASSERT(a_sweep_in_store, aclk, aresetn,
        (state_reg == S_SWEEP) |-> (sweep_cnt_reg <= LAST_ADDR))
    `LDFB_ASSERT(a_empty_range, aclk, aresetn,
        !pending_reg |-> ((low_mark_reg == LAST_ADDR) && (high_mark_reg == '0)))
    `LDFB_ASSERT(a_write_states, aclk, aresetn,
        ram_we |-> ((state_reg == S_SWEEP) || (state_reg == S_PLOT_WR)))
    `LDFB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)

endmodule

FILE: src/ldfb_ram.sv
module ldfb_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9600
    )
    (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/ldfb_stepper.sv
module ldfb_stepper
    import ldfb_pkg::*;
    (
    input  logic           clk,
    input  step_ctrl_t     ctrl,
    input  logic [X_W-1:0] x_start,
    input  logic [Y_W-1:0] y_start,
    input  logic [X_W-1:0] x_end,
    input  logic [Y_W-1:0] y_end,
    output step_stat_t     stat
    );

    logic [X_W-1:0]          x_reg, x_end_reg;
    logic [Y_W-1:0]          y_reg, y_end_reg;
    logic signed [ERR_W-1:0] err_reg, inc_reg, both_reg;
    logic                    x_major_reg, x_neg_reg, y_neg_reg;

    logic [X_W-1:0]          adx, ady, amaj, amin;
    logic                    x_neg, y_neg, x_major;
    logic signed [ERR_W-1:0] min_e, maj_e;
    logic                    err_nonneg, move_x, move_y;

    always_comb begin
        x_neg   = x_end < x_start;
        y_neg   = y_end < y_start;
        adx     = x_neg ? (x_start - x_end) : (x_end - x_start);
        ady     = X_W'(y_neg ? (y_start - y_end) : (y_end - y_start));
        x_major = adx > ady;
        amaj    = x_major ? adx : ady;
        amin    = x_major ? ady : adx;
        min_e   = ERR_W'(amin);
        maj_e   = ERR_W'(amaj);
    end

    assign err_nonneg = !err_reg[ERR_W-1];
    assign move_x     = x_major_reg || err_nonneg;
    assign move_y     = !x_major_reg || err_nonneg;

    always_ff @(posedge clk) begin
        if (ctrl.load) begin
            x_reg       <= x_start;
            y_reg       <= y_start;
            x_end_reg   <= x_end;
            y_end_reg   <= y_end;
            x_neg_reg   <= x_neg;
            y_neg_reg   <= y_neg;
            x_major_reg <= x_major;
            err_reg     <= (min_e <<< 1) - maj_e;
            inc_reg     <= min_e <<< 1;
            both_reg    <= (min_e - maj_e) <<< 1;
        end else if (ctrl.advance) begin
            err_reg <= err_reg + (err_nonneg ? both_reg : inc_reg);
            if (move_x) begin
                x_reg <= x_neg_reg ? (x_reg - X_W'(1)) : (x_reg + X_W'(1));
            end
            if (move_y) begin
                y_reg <= y_neg_reg ? (y_reg - Y_W'(1)) : (y_reg + Y_W'(1));
            end
        end
    end

    assign stat.x    = x_reg;
    assign stat.y    = y_reg;
    assign stat.last = x_major_reg ? (x_reg == x_end_reg) : (y_reg == y_end_reg);

endmodule

FILE: dv/tb.sv
module tb;
    import ldfb_pkg::*;

    localparam int ROW_BYTES    = (DISPLAY_WIDTH_DEF + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * DISPLAY_HEIGHT_DEF;
    localparam int RANDOM_ITEMS = 1024;
    localparam int QUIET_LIMIT  = 60000;

    typedef struct packed {
        logic [1:0]         op;
        logic [X_W-1:0]     xs;
        logic [Y_W-1:0]     ys;
        logic [X_W-1:0]     xe;
        logic [Y_W-1:0]     ye;
        logic [1:0]         mode;
        logic [BADDR_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [7:0]         data;
        logic [BADDR_W-1:0] lo;
        logic [BADDR_W-1:0] hi;
        logic               flag;
    } status_t;

    typedef struct packed {
        cmd_t    c;
        logic    typed;
        status_t want;
    } row_t;

    localparam row_t DIRECTED [25] = '{
        '{'{OP_TAKE,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0},
            1'b1, '{8'h00, 14'd9599, 14'd0, 1'b0}},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0},
            1'b1, '{8'h00, 14'd9599, 14'd0, 1'b0}},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_SET,    14'd9599},
            1'b1, '{8'h00, 14'd9599, 14'd0, 1'b0}},
        '{'{OP_READ,  9'd511, 8'd255, 9'd511, 8'd255, PM_KEEP,   14'd16383},
            1'b1, '{8'h00, 14'd9599, 14'd0, 1'b0}},
        '{'{OP_DRAW,  9'd0,   8'd0,   9'd0,   8'd0,   PM_SET,    14'd0},
            1'b1, '{8'h00, 14'd0, 14'd0, 1'b1}},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_SET,    14'd0},
            1'b1, '{8'h80, 14'd0, 14'd0, 1'b1}},
        '{'{OP_DRAW,  9'd319, 8'd239, 9'd319, 8'd239, PM_SET,    14'd0},
            1'b1, '{8'h00, 14'd0, 14'd9599, 1'b1}},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_SET,    14'd9599},
            1'b1, '{8'h01, 14'd0, 14'd9599, 1'b1}},
        '{'{OP_TAKE,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0},
            1'b1, '{8'h00, 14'd0, 14'd9599, 1'b1}},
        '{'{OP_TAKE,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0},
            1'b1, '{8'h00, 14'd9599, 14'd0, 1'b0}},
        '{'{OP_DRAW,  9'd320, 8'd240, 9'd511, 8'd255, PM_SET,    14'd0},
            1'b1, '{8'h00, 14'd9599, 14'd0, 1'b1}},
        '{'{OP_TAKE,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0},
            1'b1, '{8'h00, 14'd9599, 14'd0, 1'b1}},
        '{'{OP_DRAW,  9'd0,   8'd10,  9'd319, 8'd10,  PM_TOGGLE, 14'd0}, 1'b0, '0},
        '{'{OP_DRAW,  9'd5,   8'd0,   9'd5,   8'd239, PM_SET,    14'd0}, 1'b0, '0},
        '{'{OP_DRAW,  9'd319, 8'd0,   9'd0,   8'd239, PM_CLEAR,  14'd0}, 1'b0, '0},
        '{'{OP_DRAW,  9'd300, 8'd200, 9'd290, 8'd20,  PM_KEEP,   14'd0}, 1'b0, '0},
        '{'{OP_DRAW,  9'd310, 8'd230, 9'd511, 8'd255, PM_SET,    14'd0}, 1'b0, '0},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd400}, 1'b0, '0},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd405}, 1'b0, '0},
        '{'{OP_CLEAR, 9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0},
            1'b1, '{8'h00, 14'd0, 14'd9599, 1'b1}},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd400},
            1'b1, '{8'h00, 14'd0, 14'd9599, 1'b1}},
        '{'{OP_DRAW,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0}, 1'b0, '0},
        '{'{OP_TAKE,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0}, 1'b0, '0},
        '{'{OP_DRAW,  9'd0,   8'd0,   9'd511, 8'd255, PM_TOGGLE, 14'd0}, 1'b0, '0},
        '{'{OP_READ,  9'd0,   8'd0,   9'd0,   8'd0,   PM_CLEAR,  14'd0}, 1'b0, '0}
    };

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode       = '0;
    logic [X_W-1:0]     s_x_start      = '0;
    logic [Y_W-1:0]     s_y_start      = '0;
    logic [X_W-1:0]     s_x_end        = '0;
    logic [Y_W-1:0]     s_y_end        = '0;
    logic [1:0]         s_pixel_mode   = '0;
    logic [BADDR_W-1:0] s_byte_address = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [7:0]         m_read_data;
    logic [BADDR_W-1:0] m_dirty_low;
    logic [BADDR_W-1:0] m_dirty_high;
    logic               m_dirty_flag;

    logic [7:0]         shadow_fb [STORE_BYTES];
    int                 shadow_low     = STORE_BYTES - 1;
    int                 shadow_high    = 0;
    logic               shadow_pending = 1'b0;

    status_t            status_q [$];
    row_t               preset_q [$];
    int                 send_idle_pct  = 0;
    int                 stall_pct      = 0;
    int                 fail_count     = 0;
    int                 quiet_cycles   = 0;
    status_t            want_st;
    status_t            next_st;
    row_t               acc_row;

    line_draw_framebuffer_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_x_start      (s_x_start),
        .s_y_start      (s_y_start),
        .s_x_end        (s_x_end),
        .s_y_end        (s_y_end),
        .s_pixel_mode   (s_pixel_mode),
        .s_byte_address (s_byte_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_dirty_low    (m_dirty_low),
        .m_dirty_high   (m_dirty_high),
        .m_dirty_flag   (m_dirty_flag)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void plot_pixel(int x, int y, logic [1:0] mode);
        int         idx;
        logic [7:0] mask;
        if (x < 0 || y < 0 || x >= DISPLAY_WIDTH_DEF || y >= DISPLAY_HEIGHT_DEF) return;
        idx  = y * ROW_BYTES + x / 8;
        mask = 8'h80 >> (x % 8);
        case (mode)
            PM_CLEAR:  shadow_fb[idx] = shadow_fb[idx] & ~mask;
            PM_SET:    shadow_fb[idx] = shadow_fb[idx] | mask;
            PM_TOGGLE: shadow_fb[idx] = shadow_fb[idx] ^ mask;
            default: ;
        endcase
        if (idx < shadow_low) shadow_low = idx;
        if (idx > shadow_high) shadow_high = idx;
        shadow_pending = 1'b1;
    endfunction

    function automatic status_t predict_status(cmd_t c);
        status_t st;
        int      x, y, x1, y1, dx, dy, sx, sy, err;
        st = '0;
        case (c.op)
            OP_DRAW: begin
                x  = c.xs;
                y  = c.ys;
                x1 = c.xe;
                y1 = c.ye;
                dx = x1 - x;
                dy = y1 - y;
                sx = 1;
                sy = 1;
                if (dx < 0) begin
                    dx = -dx;
                    sx = -1;
                end
                if (dy < 0) begin
                    dy = -dy;
                    sy = -1;
                end
                dx = dx * 2;
                dy = dy * 2;
                plot_pixel(x, y, c.mode);
                if (dx > dy) begin
                    err = dy - dx / 2;
                    while (x != x1) begin
                        if (err >= 0) begin
                            y   = y + sy;
                            err = err - dx;
                        end
                        x   = x + sx;
                        err = err + dy;
                        plot_pixel(x, y, c.mode);
                    end
                end else begin
                    err = dx - dy / 2;
                    while (y != y1) begin
                        if (err >= 0) begin
                            x   = x + sx;
                            err = err - dy;
                        end
                        y   = y + sy;
                        err = err + dx;
                        plot_pixel(x, y, c.mode);
                    end
                end
                shadow_pending = 1'b1;
            end
            OP_CLEAR: begin
                for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = '0;
                shadow_low     = 0;
                shadow_high    = STORE_BYTES - 1;
                shadow_pending = 1'b1;
            end
            OP_READ: begin
                if (c.addr < STORE_BYTES) st.data = shadow_fb[c.addr];
            end
            default: ;
        endcase
        st.lo   = shadow_low[BADDR_W-1:0];
        st.hi   = shadow_high[BADDR_W-1:0];
        st.flag = shadow_pending;
        if (c.op == OP_TAKE) begin
            shadow_low     = STORE_BYTES - 1;
            shadow_high    = 0;
            shadow_pending = 1'b0;
        end
        return st;
    endfunction

    task automatic report_mismatch(string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic send_row(input row_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        preset_q.push_back(r);
        s_valid        <= 1'b1;
        s_opcode       <= r.c.op;
        s_x_start      <= r.c.xs;
        s_y_start      <= r.c.ys;
        s_x_end        <= r.c.xe;
        s_y_end        <= r.c.ye;
        s_pixel_mode   <= r.c.mode;
        s_byte_address <= r.c.addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result with no transaction pending");
                end else begin
                    want_st = status_q.pop_front();
                    if (m_read_data !== want_st.data)
                        report_mismatch($sformatf("read_data got %02h want %02h",
                                                  m_read_data, want_st.data));
                    if (m_dirty_low !== want_st.lo)
                        report_mismatch($sformatf("dirty_low got %0d want %0d",
                                                  m_dirty_low, want_st.lo));
                    if (m_dirty_high !== want_st.hi)
                        report_mismatch($sformatf("dirty_high got %0d want %0d",
                                                  m_dirty_high, want_st.hi));
                    if (m_dirty_flag !== want_st.flag)
                        report_mismatch($sformatf("dirty_flag got %0b want %0b",
                                                  m_dirty_flag, want_st.flag));
                end
            end
            if (s_valid && s_ready) begin
                acc_row = preset_q.pop_front();
                next_st = predict_status('{s_opcode, s_x_start, s_y_start, s_x_end,
                                           s_y_end, s_pixel_mode, s_byte_address});
                if (acc_row.typed) next_st = acc_row.want;
                status_q.push_back(next_st);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        row_t r;
        int   pick;
        int   tmp;
        int   recent_addr;
        recent_addr = 0;
        for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) send_row(DIRECTED[i]);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            repeat (RANDOM_ITEMS / 4) begin
                r        = '0;
                r.c.xs   = X_W'($urandom_range(511));
                r.c.ys   = Y_W'($urandom_range(255));
                r.c.xe   = X_W'($urandom_range(511));
                r.c.ye   = Y_W'($urandom_range(255));
                r.c.mode = 2'($urandom_range(3));
                r.c.addr = BADDR_W'($urandom_range(16383));
                pick     = $urandom_range(99);
                if (pick < 55) begin
                    r.c.op = OP_DRAW;
                    if ($urandom_range(9) != 0) r.c.xs = X_W'($urandom_range(319));
                    if ($urandom_range(9) != 0) r.c.ys = Y_W'($urandom_range(239));
                    // keep most lines short
                    if ($urandom_range(9) < 7) begin
                        tmp = int'(r.c.xs) + int'($urandom_range(24)) - 12;
                        r.c.xe = (tmp < 0) ? 9'd0 : (tmp > 511) ? 9'd511 : tmp[8:0];
                        tmp = int'(r.c.ys) + int'($urandom_range(24)) - 12;
                        r.c.ye = (tmp < 0) ? 8'd0 : (tmp > 255) ? 8'd255 : tmp[7:0];
                    end
                    if (r.c.xs < DISPLAY_WIDTH_DEF && r.c.ys < DISPLAY_HEIGHT_DEF)
                        recent_addr = r.c.ys * ROW_BYTES + r.c.xs / 8;
                end else if (pick < 57) begin
                    r.c.op = OP_CLEAR;
                end else if (pick < 82) begin
                    r.c.op = OP_READ;
                    tmp = $urandom_range(9);
                    if (tmp < 6) r.c.addr = BADDR_W'(recent_addr);
                    else if (tmp < 9) r.c.addr = BADDR_W'($urandom_range(STORE_BYTES - 1));
                end else begin
                    r.c.op = OP_TAKE;
                end
                send_row(r);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (status_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
